// ===== src/utf8pm_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8pm_pkg
// Shared types, constants and helpers of the UTF-8 position mapper.
// ----------------------------------------------------------------------------
package utf8pm_pkg;

    localparam int OFFSET_W = 32;
    localparam int TGT_W    = 32;
    localparam int CMP_W    = ((OFFSET_W > TGT_W) ? OFFSET_W : TGT_W) + 1;
    localparam int CFG_AW   = 3;
    localparam int BQ_DEPTH = 4;
    localparam int BQ_AW    = 2;
    localparam int RQ_DEPTH = 2;
    localparam int RQ_AW    = 1;

    typedef logic [OFFSET_W-1:0] t_cnt;
    typedef logic [OFFSET_W:0]   t_cntx;
    typedef logic [CMP_W-1:0]    t_cmp;
    typedef logic [TGT_W-1:0]    t_tgt;
    typedef logic [BQ_AW:0]      t_bqc;
    typedef logic [RQ_AW:0]      t_rqc;

    localparam logic [CFG_AW-1:0] CFG_ENCODING  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_KIND      = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_TGT_OFF   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_TGT_LINE  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_TGT_CHR   = 3'd4;

    localparam logic QK_OFFSET   = 1'b0;
    localparam logic QK_POSITION = 1'b1;

    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] NEWLINE   = 8'h0A;

    typedef enum logic [1:0] {
        PH_SCAN = 2'd0,
        PH_WALK = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef struct packed {
        logic encoding_utf16;
        logic query_kind;
        t_tgt target_offset;
        t_tgt target_line;
        t_tgt target_character;
    } t_cfg;

    // one accepted item: leading single-byte characters, then at most one framed character
    typedef struct packed {
        logic [1:0] pre;
        logic       ev_vld;
        logic [2:0] ev_take;
        logic       ev_wide;
        logic       ev_nl;
        logic       last;
    } t_batch;

    typedef struct packed {
        logic found;
        t_tgt line_number;
        t_tgt character_number;
        t_tgt byte_offset_out;
    } t_res;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd1;
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            n = 3'd2;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            n = 3'd3;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            n = 3'd4;
        end
        return n;
    endfunction

endpackage

// ===== src/utf8pm_front.sv =====
// ----------------------------------------------------------------------------
// utf8pm_front
// Accepts source bytes, frames UTF-8 sequences and queues one batch per item.
// ----------------------------------------------------------------------------
module utf8pm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_source_byte,
    input  logic               i_no_byte,
    input  logic               i_last_byte,
    input  logic               i_bq_pop,
    output logic               o_bq_vld,
    output utf8pm_pkg::t_batch o_bq_head
);

    logic [1:0]             r_have, n_have;
    logic [2:0]             r_need, n_need;
    utf8pm_pkg::t_batch     r_bq [utf8pm_pkg::BQ_DEPTH];
    logic [utf8pm_pkg::BQ_AW-1:0] r_wp, r_rp;
    utf8pm_pkg::t_bqc       r_cnt;
    utf8pm_pkg::t_batch     bt;
    logic                   acc, cont, nl;
    logic [2:0]             slen;

    assign full      = (r_cnt == utf8pm_pkg::t_bqc'(utf8pm_pkg::BQ_DEPTH));
    assign acc       = push && !full;
    assign o_bq_vld  = (r_cnt != '0);
    assign o_bq_head = r_bq[r_rp];

    assign cont = ((i_source_byte & utf8pm_pkg::CONT_MASK) == utf8pm_pkg::CONT_TAG);
    assign nl   = (i_source_byte == utf8pm_pkg::NEWLINE);
    assign slen = utf8pm_pkg::seq_len(i_source_byte);

    always_comb begin
        bt      = '0;
        bt.last = i_last_byte;
        n_have  = r_have;
        n_need  = r_need;
        if (i_no_byte) begin
            if (i_last_byte) begin
                bt.pre = r_have;
            end
        end else if (r_have == 2'd0) begin
            if (slen == 3'd1 || i_last_byte) begin
                bt.ev_vld  = 1'b1;
                bt.ev_take = 3'd1;
                bt.ev_nl   = nl;
            end else begin
                n_have = 2'd1;
                n_need = slen;
            end
        end else if (cont) begin
            if ((3'({1'b0, r_have}) + 3'd1) == r_need) begin
                bt.ev_vld  = 1'b1;
                bt.ev_take = r_need;
                bt.ev_wide = (r_need == 3'd4);
                n_have     = 2'd0;
            end else if (i_last_byte) begin
                bt.pre     = r_have;
                bt.ev_vld  = 1'b1;
                bt.ev_take = 3'd1;
            end else begin
                n_have = r_have + 2'd1;
            end
        end else begin
            // broken sequence: held bytes go out one at a time, new byte starts afresh
            bt.pre = r_have;
            if (slen == 3'd1 || i_last_byte) begin
                bt.ev_vld  = 1'b1;
                bt.ev_take = 3'd1;
                bt.ev_nl   = nl;
                n_have     = 2'd0;
            end else begin
                n_have = 2'd1;
                n_need = slen;
            end
        end
        if (i_last_byte) begin
            n_have = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 2'd0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            if (acc) begin
                r_have <= n_have;
                r_wp   <= r_wp + 1'b1;
            end
            if (i_bq_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({acc, i_bq_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_need     <= n_need;
            r_bq[r_wp] <= bt;
        end
    end

endmodule

// ===== src/utf8pm_back.sv =====
// ----------------------------------------------------------------------------
// utf8pm_back
// One character per cycle while results fit; keeps counters, queues results.
// ----------------------------------------------------------------------------
module utf8pm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  utf8pm_pkg::t_cfg   i_cfg,
    input  logic               i_bq_vld,
    input  utf8pm_pkg::t_batch i_bq_head,
    output logic               o_bq_pop,
    input  logic               i_res_pop,
    output logic               o_res_empty,
    output utf8pm_pkg::t_res   o_res
);

    typedef struct packed {
        utf8pm_pkg::t_phase phase;
        logic               found;
    } t_dec;

    function automatic t_dec settle(input t_dec cur, input utf8pm_pkg::t_cnt line,
                                    input utf8pm_pkg::t_cnt chr,
                                    input utf8pm_pkg::t_cnt byt,
                                    input utf8pm_pkg::t_cfg cfg);
        t_dec d;
        d = cur;
        if (d.phase != utf8pm_pkg::PH_DONE) begin
            if (cfg.query_kind == utf8pm_pkg::QK_OFFSET) begin
                if (utf8pm_pkg::t_cmp'(byt) == utf8pm_pkg::t_cmp'(cfg.target_offset)) begin
                    d.phase = utf8pm_pkg::PH_DONE;
                    d.found = 1'b1;
                end
            end else begin
                if (d.phase == utf8pm_pkg::PH_SCAN &&
                    utf8pm_pkg::t_cmp'(line) == utf8pm_pkg::t_cmp'(cfg.target_line)) begin
                    d.phase = utf8pm_pkg::PH_WALK;
                end
                if (d.phase == utf8pm_pkg::PH_WALK &&
                    utf8pm_pkg::t_cmp'(chr) == utf8pm_pkg::t_cmp'(cfg.target_character)) begin
                    d.phase = utf8pm_pkg::PH_DONE;
                    d.found = 1'b1;
                end
            end
        end
        return d;
    endfunction

    utf8pm_pkg::t_phase r_phase;
    logic               r_found;
    utf8pm_pkg::t_cnt   r_line, r_chr, r_byte;
    utf8pm_pkg::t_cnt   n_line, n_chr, n_byte;
    logic [1:0]         r_step;
    utf8pm_pkg::t_res   r_rq [utf8pm_pkg::RQ_DEPTH];
    logic [utf8pm_pkg::RQ_AW-1:0] r_rwp, r_rrp;
    utf8pm_pkg::t_rqc   r_rcnt;

    t_dec               d0, d1, d2, d3;
    logic [2:0]         n_ev, e_take, units;
    logic               is_pre, e_wide, e_nl, final_step, res_full, go, res_push, res_pop;
    logic               ovf, scan1, kind_pos;
    utf8pm_pkg::t_cntx  sum_b, sum_c;
    utf8pm_pkg::t_res   res;

    assign res_full    = (r_rcnt == utf8pm_pkg::t_rqc'(utf8pm_pkg::RQ_DEPTH));
    assign o_res_empty = (r_rcnt == '0);
    assign o_res       = r_rq[r_rrp];
    assign res_pop     = i_res_pop && !o_res_empty;
    assign kind_pos    = (i_cfg.query_kind == utf8pm_pkg::QK_POSITION);

    always_comb begin
        n_ev       = 3'(i_bq_head.pre) + 3'(i_bq_head.ev_vld);
        is_pre     = (r_step < i_bq_head.pre);
        e_take     = is_pre ? 3'd1 : i_bq_head.ev_take;
        e_wide     = is_pre ? 1'b0 : i_bq_head.ev_wide;
        e_nl       = is_pre ? 1'b0 : i_bq_head.ev_nl;
        final_step = (n_ev == 3'd0) || (3'({1'b0, r_step}) == (n_ev - 3'd1));
        go         = i_bq_vld && !(i_bq_head.last && final_step && res_full);
        o_bq_pop   = go && final_step;
        res_push   = o_bq_pop && i_bq_head.last;

        d0.phase = r_phase;
        d0.found = r_found;
        d1       = settle(d0, r_line, r_chr, r_byte, i_cfg);

        sum_b = utf8pm_pkg::t_cntx'(r_byte) + utf8pm_pkg::t_cntx'(e_take);
        ovf   = sum_b[utf8pm_pkg::OFFSET_W];
        units = i_cfg.encoding_utf16 ? (e_wide ? 3'd2 : 3'd1) : e_take;
        sum_c = utf8pm_pkg::t_cntx'(r_chr) + utf8pm_pkg::t_cntx'(units);
        scan1 = kind_pos && (d1.phase == utf8pm_pkg::PH_SCAN);

        d2     = d1;
        n_line = r_line;
        n_chr  = r_chr;
        n_byte = r_byte;
        if (n_ev != 3'd0 && d1.phase != utf8pm_pkg::PH_DONE) begin
            if (scan1) begin
                if (ovf) begin
                    d2 = '{utf8pm_pkg::PH_DONE, 1'b0};
                end else begin
                    n_byte = sum_b[utf8pm_pkg::OFFSET_W-1:0];
                    if (e_nl) begin
                        n_line = r_line + 1'b1;
                    end
                end
            end else if (e_nl) begin
                if (kind_pos || ovf) begin
                    d2 = '{utf8pm_pkg::PH_DONE, 1'b0};
                end else begin
                    n_byte = sum_b[utf8pm_pkg::OFFSET_W-1:0];
                    n_line = r_line + 1'b1;
                    n_chr  = '0;
                end
            end else if (!kind_pos &&
                         utf8pm_pkg::t_cmp'(sum_b) > utf8pm_pkg::t_cmp'(i_cfg.target_offset)) begin
                d2 = '{utf8pm_pkg::PH_DONE, 1'b0};
            end else if (kind_pos &&
                         utf8pm_pkg::t_cmp'(sum_c) > utf8pm_pkg::t_cmp'(i_cfg.target_character)) begin
                d2 = '{utf8pm_pkg::PH_DONE, 1'b0};
            end else if (ovf) begin
                d2 = '{utf8pm_pkg::PH_DONE, 1'b0};
            end else begin
                n_byte = sum_b[utf8pm_pkg::OFFSET_W-1:0];
                n_chr  = sum_c[utf8pm_pkg::OFFSET_W-1:0];
            end
        end
        d3 = settle(d2, n_line, n_chr, n_byte, i_cfg);

        res = '0;
        res.found = (d3.phase == utf8pm_pkg::PH_DONE) && d3.found;
        if (res.found) begin
            if (kind_pos) begin
                res.byte_offset_out = utf8pm_pkg::t_tgt'(n_byte);
            end else begin
                res.line_number      = utf8pm_pkg::t_tgt'(n_line);
                res.character_number = utf8pm_pkg::t_tgt'(n_chr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= utf8pm_pkg::PH_SCAN;
            r_found <= 1'b0;
            r_line  <= '0;
            r_chr   <= '0;
            r_byte  <= '0;
            r_step  <= 2'd0;
            r_rwp   <= '0;
            r_rrp   <= '0;
            r_rcnt  <= '0;
        end else begin
            if (go) begin
                if (res_push) begin
                    r_phase <= utf8pm_pkg::PH_SCAN;
                    r_found <= 1'b0;
                    r_line  <= '0;
                    r_chr   <= '0;
                    r_byte  <= '0;
                end else begin
                    r_phase <= d3.phase;
                    r_found <= d3.found;
                    r_line  <= n_line;
                    r_chr   <= n_chr;
                    r_byte  <= n_byte;
                end
                r_step <= final_step ? 2'd0 : r_step + 2'd1;
            end
            if (res_push) begin
                r_rwp <= r_rwp + 1'b1;
            end
            if (res_pop) begin
                r_rrp <= r_rrp + 1'b1;
            end
            case ({res_push, res_pop})
                2'b10:   r_rcnt <= r_rcnt + 1'b1;
                2'b01:   r_rcnt <= r_rcnt - 1'b1;
                default: r_rcnt <= r_rcnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_rq[r_rwp] <= res;
        end
    end

endmodule

// ===== src/utf8_position_mapper.sv =====
// ----------------------------------------------------------------------------
// utf8_position_mapper
// Maps between byte offsets and line/character positions of a UTF-8 source.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive one source byte per transfer on push while full is low;
//   no_byte marks an item without a byte, last_byte ends the source.
//   Result queue: while empty is low the oldest result is on the o_ ports;
//   pop takes it. One result comes for every item with last_byte set.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once
//   (0 encoding, 1 query kind, 2 offset, 3 line, 4 character); write only
//   while no source is in flight.
//   Throughput: one item per cycle for well-formed text. A broken or cut-short
//   sequence gives the character walker extra characters to step through, as
//   it retires one character a cycle; a four-entry queue absorbs this.
//   Path: the last item is registered in the input queue, then its result in
//   the result queue once the walker has stepped through that item.
//   Stalls: with two results waiting the walker holds at the end of the next
//   source; the input queue then fills and full rises.
//   Reset: queues and counters clear; encoding resets to UTF-16 units, query
//   kind to offset lookup, targets to zero.
// ----------------------------------------------------------------------------
module utf8_position_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_source_byte,
    input  logic        i_no_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_found,
    output logic [31:0] o_line_number,
    output logic [31:0] o_character_number,
    output logic [31:0] o_byte_offset_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    utf8pm_pkg::t_cfg   r_cfg;
    utf8pm_pkg::t_batch bq_head;
    utf8pm_pkg::t_res   res;
    logic               bq_vld, bq_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.encoding_utf16   <= 1'b1;
            r_cfg.query_kind       <= utf8pm_pkg::QK_OFFSET;
            r_cfg.target_offset    <= '0;
            r_cfg.target_line      <= '0;
            r_cfg.target_character <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                utf8pm_pkg::CFG_ENCODING: r_cfg.encoding_utf16   <= i_cfg_data[0];
                utf8pm_pkg::CFG_KIND:     r_cfg.query_kind       <= i_cfg_data[0];
                utf8pm_pkg::CFG_TGT_OFF:  r_cfg.target_offset    <= i_cfg_data;
                utf8pm_pkg::CFG_TGT_LINE: r_cfg.target_line      <= i_cfg_data;
                utf8pm_pkg::CFG_TGT_CHR:  r_cfg.target_character <= i_cfg_data;
                default:                  r_cfg                  <= r_cfg;
            endcase
        end
    end

    utf8pm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_source_byte (i_source_byte),
        .i_no_byte     (i_no_byte),
        .i_last_byte   (i_last_byte),
        .i_bq_pop      (bq_pop),
        .o_bq_vld      (bq_vld),
        .o_bq_head     (bq_head)
    );

    utf8pm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_bq_vld    (bq_vld),
        .i_bq_head   (bq_head),
        .o_bq_pop    (bq_pop),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_res       (res)
    );

    assign o_found            = res.found;
    assign o_line_number      = res.line_number;
    assign o_character_number = res.character_number;
    assign o_byte_offset_out  = res.byte_offset_out;

`ifndef SYNTHESIS
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_fail_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_found) |->
        (o_line_number == '0 && o_character_number == '0 && o_byte_offset_out == '0))
        else $error("failed mapping carries non-zero fields");

    a_one_mode_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |->
        (o_byte_offset_out == '0 || (o_line_number == '0 && o_character_number == '0)))
        else $error("result mixes position and offset fields");
`endif

endmodule
